@@ rtl/core/csev_pkg.sv @@
// Shared constants and types for the Chebyshev series evaluator.
// No dependencies; the RTL files but csev_coeff_ram refer to it by scoped names, tb imports it.
`default_nettype none

package csev_pkg;

   localparam int MAX_TERMS = 64;
   localparam int ADDR_W    = $clog2(MAX_TERMS);
   localparam int VAL_W     = 32;
   localparam int FRAC_BITS = 16;
   localparam int OP_W      = 2;
   localparam int IDX_W     = 6;
   localparam int CSR_IDX_W = 2;

   // divider operand widths for the domain mapping
   localparam int DEN_W     = VAL_W + 1;
   localparam int NUM_W     = DEN_W + FRAC_BITS + 1;
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);

   localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OP_W-1:0] OP_EVAL_T  = 2'd1;
   localparam logic [OP_W-1:0] OP_EVAL_U  = 2'd2;
   localparam logic [OP_W-1:0] OP_DERIV   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_DEGREE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END    = 2'd2;

   localparam logic [IDX_W-1:0]        DEGREE_RST = '0;
   localparam logic signed [VAL_W-1:0] START_RST  = -32'sd65536;
   localparam logic signed [VAL_W-1:0] END_RST    = 32'sd65536;

   localparam logic signed [63:0] SAT_HI    = (64'sd1 <<< (VAL_W - 1)) - 64'sd1;
   localparam logic signed [63:0] SAT_LO    = -(64'sd1 <<< (VAL_W - 1));
   localparam logic signed [63:0] ONE_Q     = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] HALF_T    = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [63:0] HALF_2X   = 64'sd1 <<< (FRAC_BITS - 2);

   typedef struct packed {
      logic                    ovf;
      logic signed [VAL_W-1:0] value;
   } sat_type;

endpackage

`default_nettype wire

@@ rtl/core/csev_req_if.sv @@
// Request channel of the evaluator: valid/ready plus op, index and operand.
// Depends on csev_pkg.
`default_nettype none

interface csev_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [csev_pkg::OP_W-1:0]             op;
   logic [csev_pkg::IDX_W-1:0]            coeff_index;
   logic signed [csev_pkg::VAL_W-1:0]     operand;

   modport source (output valid, output op, output coeff_index, output operand,
                   input ready);
   modport sink   (input valid, input op, input coeff_index, input operand,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/core/csev_rsp_if.sv @@
// Response channel of the evaluator: valid/ready plus result and error flag.
// Depends on csev_pkg.
`default_nettype none

interface csev_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [csev_pkg::VAL_W-1:0]     result;
   logic                                  error;

   modport source (output valid, output result, output error, input ready);
   modport sink   (input valid, input result, input error, output ready);
endinterface

`default_nettype wire

@@ rtl/core/csev_coeff_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module csev_coeff_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] store_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/csev_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle, for the domain mapping.
// Depends on csev_pkg for operand and counter widths.
`default_nettype none

module csev_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [csev_pkg::NUM_W-1:0]     dividend,
   input  wire logic [csev_pkg::DEN_W-1:0]     divisor,
   output logic                                done,
   output logic [csev_pkg::NUM_W-1:0]          quotient
);

   logic [csev_pkg::DEN_W-1:0]     rem_ff, rem_in;
   logic [csev_pkg::NUM_W-1:0]     quo_ff, quo_in;
   logic [csev_pkg::DEN_W-1:0]     dsr_ff, dsr_in;
   logic [csev_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [csev_pkg::DEN_W:0]       shifted;
   logic [csev_pkg::DEN_W+1:0]     trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[csev_pkg::NUM_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = csev_pkg::DIV_CNT_W'(csev_pkg::NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[csev_pkg::DEN_W+1]) begin
            rem_in = trial[csev_pkg::DEN_W-1:0];
            quo_in = {quo_ff[csev_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[csev_pkg::DEN_W-1:0];
            quo_in = {quo_ff[csev_pkg::NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == csev_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ rtl/core/chebyshev_series_evaluator.sv @@
// Chebyshev series evaluator top level: control, registers and Clenshaw datapath.
// Depends on csev_pkg, csev_req_if, csev_rsp_if, csev_coeff_ram and csev_div.
//
// Usage: req_chan carries items of op, coeff_index and operand (signed Q16.16).
// A load item writes one coefficient into the coefficient memory in the cycle it
// is accepted and gives no result. An evaluate item (T value, U value or T
// derivative) gives one item on rsp_chan: the saturated Q16.16 result and an
// error flag. The csr_ port writes degree, interval_start and interval_end.
// Evaluation: the domain mapping runs through the 50-step restoring divider, and
// each Clenshaw step runs through the multiplier and the coefficient memory read
// port. An empty interval answers without a division. One item is worked on at
// a time; a load leaves the block ready for the next item.
// The result waits in an output register; the next item is accepted while it
// waits, and a later result holds until the receiver takes the earlier one.
// Reset is synchronous: registers return to degree 0 and interval [-1, 1];
// the coefficient memory keeps no reset value and must be loaded before use.
`default_nettype none

module chebyshev_series_evaluator (
   input  wire logic                                clock,
   input  wire logic                                reset,
   csev_req_if.sink                                 req_chan,
   csev_rsp_if.source                               rsp_chan,
   input  wire logic                                csr_wr_en,
   input  wire logic [csev_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [csev_pkg::VAL_W-1:0]          csr_wdata
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_PREP    = 4'd1;
   localparam logic [3:0] S_ABS     = 4'd2;
   localparam logic [3:0] S_DIVGO   = 4'd3;
   localparam logic [3:0] S_DIVWAIT = 4'd4;
   localparam logic [3:0] S_XX      = 4'd5;
   localparam logic [3:0] S_FETCH   = 4'd6;
   localparam logic [3:0] S_WGT     = 4'd7;
   localparam logic [3:0] S_MUL     = 4'd8;
   localparam logic [3:0] S_ADD     = 4'd9;
   localparam logic [3:0] S_DONE    = 4'd10;

   localparam int AW  = csev_pkg::ADDR_W;
   localparam int VW  = csev_pkg::VAL_W;
   localparam int WPW = VW + AW + 1;

   function automatic csev_pkg::sat_type sat_val(input logic signed [63:0] v);
      csev_pkg::sat_type r;
      if (v > csev_pkg::SAT_HI) begin
         r.ovf   = 1'b1;
         r.value = csev_pkg::SAT_HI[VW-1:0];
      end else if (v < csev_pkg::SAT_LO) begin
         r.ovf   = 1'b1;
         r.value = csev_pkg::SAT_LO[VW-1:0];
      end else begin
         r.ovf   = 1'b0;
         r.value = v[VW-1:0];
      end
      return r;
   endfunction

   function automatic csev_pkg::sat_type weight(input logic signed [VW-1:0] c,
                                                input logic [AW-1:0] a,
                                                input logic deriv);
      logic [AW-1:0]          s;
      logic signed [WPW-1:0]  p;
      s = deriv ? a : AW'(1);
      p = c * $signed({1'b0, s});
      return sat_val(64'(p));
   endfunction

   // configuration registers
   logic [csev_pkg::IDX_W-1:0] degree_ff;
   logic signed [VW-1:0]       start_ff;
   logic signed [VW-1:0]       end_ff;

   // control
   logic [3:0]                 state_ff, state_in;
   logic [csev_pkg::OP_W-1:0]  op_ff, op_in;
   logic [AW-1:0]              addr_ff, addr_in;
   logic [AW-1:0]              stop_ff, stop_in;
   logic                       wzero_ff, wzero_in;
   logic                       sh16_ff, sh16_in;
   logic                       fin_ff, fin_in;
   logic                       err_ff, err_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // datapath
   logic signed [VW-1:0]               x_ff, x_in;
   logic signed [VW:0]                 diff_ff, diff_in;
   logic signed [VW:0]                 den_ff, den_in;
   logic                               neg_ff, neg_in;
   logic [csev_pkg::DEN_W-1:0]         nmag_ff, nmag_in;
   logic [csev_pkg::DEN_W-1:0]         dmag_ff, dmag_in;
   logic signed [csev_pkg::NUM_W:0]    sq_ff, sq_in;
   logic signed [VW-1:0]               xx_ff, xx_in;
   logic signed [VW-1:0]               b1_ff, b1_in;
   logic signed [VW-1:0]               b2_ff, b2_in;
   logic signed [VW-1:0]               w_ff, w_in;
   logic signed [VW+1:0]               t_ff, t_in;
   logic signed [63:0]                 p_ff, p_in;
   logic signed [VW-1:0]               res_ff, res_in;
   logic signed [VW-1:0]               rsp_result_ff, rsp_result_in;
   logic                               rsp_error_ff, rsp_error_in;

   // combinational helpers
   logic                        req_fire;
   logic                        ram_wr_en;
   logic                        ram_rd_en;
   logic [AW-1:0]               ram_rd_addr;
   logic [VW-1:0]               ram_rd_data;
   logic                        div_start;
   logic [csev_pkg::NUM_W-1:0]  div_dividend;
   logic                        div_done;
   logic [csev_pkg::NUM_W-1:0]  div_q;
   logic [AW-1:0]               n_clamp;
   logic                        deriv;
   logic                        fin_now;
   logic signed [63:0]          prod;
   logic signed [63:0]          q_shift;
   csev_pkg::sat_type           xx_sat;
   csev_pkg::sat_type           mq_sat;
   csev_pkg::sat_type           sum_sat;
   csev_pkg::sat_type           w_sat;

   assign req_fire      = req_chan.valid && (state_ff == S_IDLE);
   assign req_chan.ready = (state_ff == S_IDLE);
   assign ram_wr_en     = req_fire && (req_chan.op == csev_pkg::OP_LOAD) &&
                          (32'(req_chan.coeff_index) < 32'(csev_pkg::MAX_TERMS));
   assign div_dividend  = csev_pkg::NUM_W'({nmag_ff, {(csev_pkg::FRAC_BITS + 1){1'b0}}}) +
                          csev_pkg::NUM_W'(dmag_ff >> 1);
   assign deriv         = (op_ff == csev_pkg::OP_DERIV);
   assign fin_now       = (addr_ff == stop_ff);

   csev_coeff_ram #(
      .DEPTH (csev_pkg::MAX_TERMS),
      .WIDTH (VW)
   ) u_coeff_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (AW'(req_chan.coeff_index)),
      .wr_data (req_chan.operand),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   csev_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (dmag_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      if (32'(degree_ff) > 32'(csev_pkg::MAX_TERMS - 1)) begin
         n_clamp = AW'(csev_pkg::MAX_TERMS - 1);
      end else begin
         n_clamp = AW'(degree_ff);
      end
      prod    = b1_ff * xx_ff;
      q_shift = sh16_ff ? (p_ff >>> csev_pkg::FRAC_BITS) : (p_ff >>> (csev_pkg::FRAC_BITS - 1));
      xx_sat  = sat_val(64'(sq_ff) + csev_pkg::ONE_Q);
      mq_sat  = sat_val(q_shift);
      sum_sat = sat_val(64'($signed(mq_sat.value)) + 64'(t_ff));
      w_sat   = (state_ff == S_WGT) ? weight($signed(ram_rd_data), addr_ff, deriv)
                                    : weight($signed(ram_rd_data), addr_ff - 1'b1, deriv);

      state_in      = state_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      stop_in       = stop_ff;
      wzero_in      = wzero_ff;
      sh16_in       = sh16_ff;
      fin_in        = fin_ff;
      err_in        = err_ff;
      x_in          = x_ff;
      diff_in       = diff_ff;
      den_in        = den_ff;
      neg_in        = neg_ff;
      nmag_in       = nmag_ff;
      dmag_in       = dmag_ff;
      sq_in         = sq_ff;
      xx_in         = xx_ff;
      b1_in         = b1_ff;
      b2_in         = b2_ff;
      w_in          = w_ff;
      t_in          = t_ff;
      p_in          = p_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_result_in = rsp_result_ff;
      rsp_error_in  = rsp_error_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = addr_ff;
      div_start     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_chan.op != csev_pkg::OP_LOAD)) begin
               op_in    = req_chan.op;
               x_in     = req_chan.operand;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            diff_in  = (VW + 1)'(x_ff) - (VW + 1)'(end_ff);
            den_in   = (VW + 1)'(end_ff) - (VW + 1)'(start_ff);
            err_in   = 1'b0;
            state_in = S_ABS;
         end
         S_ABS: begin
            if (den_ff == '0) begin
               res_in   = '0;
               err_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               nmag_in  = diff_ff[VW] ? csev_pkg::DEN_W'(-diff_ff) : csev_pkg::DEN_W'(diff_ff);
               dmag_in  = den_ff[VW] ? csev_pkg::DEN_W'(-den_ff) : csev_pkg::DEN_W'(den_ff);
               neg_in   = diff_ff[VW] != den_ff[VW];
               state_in = S_DIVGO;
            end
         end
         S_DIVGO: begin
            div_start = 1'b1;
            state_in  = S_DIVWAIT;
         end
         S_DIVWAIT: begin
            if (div_done) begin
               sq_in    = neg_ff ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
               state_in = S_XX;
            end
         end
         S_XX: begin
            xx_in  = xx_sat.value;
            err_in = err_ff | xx_sat.ovf;
            b1_in  = '0;
            b2_in  = '0;
            stop_in = deriv ? AW'(1) : AW'(0);
            if (deriv && (n_clamp == '0)) begin
               addr_in  = AW'(1);
               wzero_in = 1'b1;
            end else begin
               addr_in  = n_clamp;
               wzero_in = 1'b0;
            end
            state_in = S_FETCH;
         end
         S_FETCH: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = addr_ff;
            state_in    = S_WGT;
         end
         S_WGT: begin
            if (wzero_ff) begin
               w_in = '0;
            end else begin
               w_in   = w_sat.value;
               err_in = err_ff | w_sat.ovf;
            end
            state_in = S_MUL;
         end
         S_MUL: begin
            sh16_in = fin_now && (op_ff == csev_pkg::OP_EVAL_T);
            fin_in  = fin_now;
            p_in    = prod + (sh16_in ? csev_pkg::HALF_T : csev_pkg::HALF_2X) -
                      64'(b1_ff[VW-1] ^ xx_ff[VW-1]);
            t_in    = (VW + 2)'(w_ff) - (VW + 2)'(b2_ff);
            ram_rd_en   = !fin_now;
            ram_rd_addr = addr_ff - 1'b1;
            state_in    = S_ADD;
         end
         S_ADD: begin
            err_in = err_ff | mq_sat.ovf | sum_sat.ovf;
            b2_in  = b1_ff;
            b1_in  = sum_sat.value;
            if (fin_ff) begin
               res_in   = sum_sat.value;
               state_in = S_DONE;
            end else begin
               w_in     = w_sat.value;
               err_in   = err_ff | mq_sat.ovf | sum_sat.ovf | w_sat.ovf;
               addr_in  = addr_ff - 1'b1;
               state_in = S_MUL;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = res_ff;
               rsp_error_in  = err_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         degree_ff    <= csev_pkg::DEGREE_RST;
         start_ff     <= csev_pkg::START_RST;
         end_ff       <= csev_pkg::END_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               csev_pkg::CSR_DEGREE: degree_ff <= csr_wdata[csev_pkg::IDX_W-1:0];
               csev_pkg::CSR_START:  start_ff  <= $signed(csr_wdata);
               csev_pkg::CSR_END:    end_ff    <= $signed(csr_wdata);
               default: begin
               end
            endcase
         end
      end
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      stop_ff       <= stop_in;
      wzero_ff      <= wzero_in;
      sh16_ff       <= sh16_in;
      fin_ff        <= fin_in;
      err_ff        <= err_in;
      x_ff          <= x_in;
      diff_ff       <= diff_in;
      den_ff        <= den_in;
      neg_ff        <= neg_in;
      nmag_ff       <= nmag_in;
      dmag_ff       <= dmag_in;
      sq_ff         <= sq_in;
      xx_ff         <= xx_in;
      b1_ff         <= b1_in;
      b2_ff         <= b2_in;
      w_ff          <= w_in;
      t_ff          <= t_in;
      p_ff          <= p_in;
      res_ff        <= res_in;
      rsp_result_ff <= rsp_result_in;
      rsp_error_ff  <= rsp_error_in;
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.result = rsp_result_ff;
   assign rsp_chan.error  = rsp_error_ff;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Testbench for chebyshev_series_evaluator: a directed table then random load and
// evaluate items, checked against a Q16.16 Clenshaw predictor kept in this file.
// Depends on csev_pkg, csev_req_if, csev_rsp_if and the evaluator RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import csev_pkg::*;

   localparam int DRAIN_CYCLES = 250;
   localparam int STALL_LIMIT  = 5000;
   localparam int LONG_HOLD    = 400;
   localparam int MAX_SHOWN    = 10;
   localparam int SPAN_COUNT   = 9;

   typedef struct packed {
      logic signed [VAL_W-1:0] result;
      logic                    error;
   } series_t;

   typedef enum bit {ROW_ITEM, ROW_CSR} row_kind_e;

   typedef struct packed {
      row_kind_e        kind;
      logic [1:0]       sel;
      logic [IDX_W-1:0] idx;
      logic [VAL_W-1:0] data;
      bit               typed;
      logic [VAL_W-1:0] want;
      logic             want_err;
   } plan_row_t;

   typedef struct {
      int               deg;
      logic [VAL_W-1:0] lo;
      logic [VAL_W-1:0] hi;
      int               items;
   } span_t;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [VAL_W-1:0]     csr_wdata;

   csev_req_if req_if ();
   csev_rsp_if rsp_if ();

   chebyshev_series_evaluator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic signed [VAL_W-1:0] coeff_shadow [MAX_TERMS];
   bit                      coeff_loaded [MAX_TERMS];
   logic [IDX_W-1:0]        degree_shadow;
   logic signed [VAL_W-1:0] span_lo;
   logic signed [VAL_W-1:0] span_hi;
   bit                      sat_hit;

   series_t series_q [$];
   int      fail_count;
   int      sender_idle;
   int      stall_pct;
   bit      long_hold_go;

   plan_row_t directed_plan [26] = '{
      '{ROW_ITEM, OP_LOAD,    6'd0,  32'h0003_0000, 1'b0, 32'h0,          1'b0},
      '{ROW_ITEM, OP_EVAL_T,  6'd63, 32'h0000_0000, 1'b1, 32'h0003_0000,  1'b0},
      '{ROW_ITEM, OP_EVAL_U,  6'd21, 32'h7FFF_FFFF, 1'b1, 32'h0003_0000,  1'b0},
      '{ROW_ITEM, OP_DERIV,   6'd42, 32'h8000_0000, 1'b1, 32'h0000_0000,  1'b0},
      '{ROW_ITEM, OP_LOAD,    6'd0,  32'h8000_0000, 1'b0, 32'h0,          1'b0},
      '{ROW_ITEM, OP_EVAL_T,  6'd0,  32'h1234_5678, 1'b1, 32'h8000_0000,  1'b0},
      '{ROW_ITEM, OP_LOAD,    6'd63, 32'h7FFF_FFFF, 1'b0, 32'h0,          1'b0},
      '{ROW_CSR,  CSR_DEGREE, 6'd0,  32'h0000_0003, 1'b0, 32'h0,          1'b0},
      '{ROW_ITEM, OP_LOAD,    6'd1,  32'h0001_8000, 1'b0, 32'h0,          1'b0},
      '{ROW_ITEM, OP_LOAD,    6'd2,  32'hFFFF_0000, 1'b0, 32'h0,          1'b0},
      '{ROW_ITEM, OP_LOAD,    6'd3,  32'h0000_4000, 1'b0, 32'h0,          1'b0},
      '{ROW_ITEM, OP_LOAD,    6'd0,  32'h0002_0000, 1'b0, 32'h0,          1'b0},
      '{ROW_ITEM, OP_EVAL_T,  6'd5,  32'h0000_8000, 1'b0, 32'h0,          1'b0},
      '{ROW_ITEM, OP_EVAL_U,  6'd9,  32'hFFFF_4000, 1'b0, 32'h0,          1'b0},
      '{ROW_ITEM, OP_DERIV,   6'd17, 32'h0001_0000, 1'b0, 32'h0,          1'b0},
      '{ROW_ITEM, OP_EVAL_T,  6'd33, 32'h7FFF_FFFF, 1'b0, 32'h0,          1'b0},
      '{ROW_CSR,  CSR_START,  6'd0,  32'h0001_0000, 1'b0, 32'h0,          1'b0},
      '{ROW_CSR,  CSR_END,    6'd0,  32'h0001_0000, 1'b0, 32'h0,          1'b0},
      '{ROW_ITEM, OP_EVAL_T,  6'd0,  32'h0000_0000, 1'b1, 32'h0000_0000,  1'b1},
      '{ROW_ITEM, OP_EVAL_U,  6'd0,  32'h7FFF_FFFF, 1'b1, 32'h0000_0000,  1'b1},
      '{ROW_ITEM, OP_DERIV,   6'd0,  32'h8000_0000, 1'b1, 32'h0000_0000,  1'b1},
      '{ROW_CSR,  CSR_START,  6'd0,  32'hFFFF_0000, 1'b0, 32'h0,          1'b0},
      '{ROW_CSR,  CSR_END,    6'd0,  32'h0001_0000, 1'b0, 32'h0,          1'b0},
      '{ROW_CSR,  CSR_DEGREE, 6'd0,  32'h0000_0001, 1'b0, 32'h0,          1'b0},
      '{ROW_ITEM, OP_DERIV,   6'd12, 32'h0000_0000, 1'b1, 32'h0001_8000,  1'b0},
      '{ROW_ITEM, OP_EVAL_U,  6'd50, 32'h0000_0000, 1'b0, 32'h0,          1'b0}
   };

   function automatic longint clip(longint v);
      if (v > SAT_HI) begin
         sat_hit = 1'b1;
         return SAT_HI;
      end
      if (v < SAT_LO) begin
         sat_hit = 1'b1;
         return SAT_LO;
      end
      return v;
   endfunction

   // round(a*b / 2^sh) with ties away from zero, saturated
   function automatic longint scaled_product(longint a, longint b, int sh);
      longint          p;
      longint unsigned m;
      longint unsigned lim;
      bit              neg;
      p   = a * b;
      neg = (a < 0) != (b < 0);
      m   = (p < 0) ? -p : p;
      m   = (m + (64'd1 << (sh - 1))) >> sh;
      lim = 64'h7FFF_FFFF + (neg ? 64'd1 : 64'd0);
      if (m > lim) begin
         sat_hit = 1'b1;
         m = lim;
      end
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic series_t clenshaw_predict(logic [OP_W-1:0] op,
                                                logic signed [VAL_W-1:0] x);
      series_t         r;
      longint          den, num, xx, b, b1, b2, w0, acc;
      longint unsigned ud, un, q;
      int              n;
      sat_hit = 1'b0;
      b1 = 0;
      b2 = 0;
      den = longint'(span_hi) - longint'(span_lo);
      if (den == 0) begin
         r.result = '0;
         r.error  = 1'b1;
         return r;
      end
      num = (longint'(x) - longint'(span_hi)) * (2 * ONE_Q);
      ud  = (den < 0) ? -den : den;
      un  = (num < 0) ? -num : num;
      q   = (un + ud / 2) / ud;
      xx  = ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
      xx  = clip(xx + ONE_Q);
      n   = int'(degree_shadow);
      if (op != OP_DERIV) begin
         for (int j = n; j > 0; j--) begin
            b  = clip(scaled_product(b1, xx, FRAC_BITS - 1) - b2 + longint'(coeff_shadow[j]));
            b2 = b1;
            b1 = b;
         end
         w0 = longint'(coeff_shadow[0]);
      end else begin
         for (int j = n - 1; j > 0; j--) begin
            b  = clip(scaled_product(b1, xx, FRAC_BITS - 1) - b2
                      + clip(longint'(j + 1) * longint'(coeff_shadow[j + 1])));
            b2 = b1;
            b1 = b;
         end
         w0 = (n >= 1) ? longint'(coeff_shadow[1]) : 0;
      end
      acc = clip(scaled_product(b1, xx, (op == OP_EVAL_T) ? FRAC_BITS : FRAC_BITS - 1)
                 - b2 + w0);
      r.result = acc[VAL_W-1:0];
      r.error  = sat_hit;
      return r;
   endfunction

   task automatic log_fault(string what, series_t want, series_t got);
      fail_count++;
      if (fail_count <= MAX_SHOWN)
         $display("mismatch (%s): expected %h err %b, got %h err %b",
                  what, want.result, want.error, got.result, got.error);
   endtask

   task automatic offer_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                             logic [VAL_W-1:0] val);
      while ($urandom_range(0, 99) < sender_idle) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.op          <= op;
      req_if.coeff_index <= idx;
      req_if.operand     <= val;
      do @(posedge clock); while (!req_if.ready);
      if (op == OP_LOAD) begin
         coeff_shadow[idx] = val;
         coeff_loaded[idx] = 1'b1;
      end
   endtask

   // drop valid, drain pending results, then let the datapath go quiet
   task automatic settle();
      req_if.valid <= 1'b0;
      while (series_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [VAL_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         CSR_DEGREE: degree_shadow = data[IDX_W-1:0];
         CSR_START:  span_lo = data;
         CSR_END:    span_hi = data;
         default: ;
      endcase
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: check results and stall at random, with one long hold-off
   initial begin
      series_t got;
      series_t want;
      int      hold_left;
      bit      hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            got.result = rsp_if.result;
            got.error  = rsp_if.error;
            if (series_q.size() == 0) begin
               log_fault("unexpected result", '0, got);
            end else begin
               want = series_q.pop_front();
               if (got.result !== want.result || got.error !== want.error)
                  log_fault("result", want, got);
            end
         end
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (long_hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tb: errors");
      $finish;
   end

   initial begin
      series_t          want;
      span_t            spans [SPAN_COUNT];
      logic [OP_W-1:0]  op;
      logic [IDX_W-1:0] idx;
      logic [VAL_W-1:0] val;
      longint           den;
      int               gap;
      int               pick;

      req_if.valid       = 1'b0;
      req_if.op          = OP_LOAD;
      req_if.coeff_index = '0;
      req_if.operand     = '0;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_DEGREE;
      csr_wdata          = '0;
      fail_count         = 0;
      sender_idle        = 0;
      stall_pct          = 0;
      long_hold_go       = 1'b0;
      degree_shadow      = DEGREE_RST;
      span_lo            = START_RST;
      span_hi            = END_RST;
      foreach (coeff_shadow[j]) begin
         coeff_shadow[j] = '0;
         coeff_loaded[j] = 1'b0;
      end

      spans[0] = '{5,  32'hFFFF_0000, 32'h0001_0000, 200};
      spans[1] = '{0,  32'h8000_0000, 32'h7FFF_FFFF, 160};
      spans[2] = '{63, 32'hFFFC_0000, 32'h0004_0000, 80};
      spans[3] = '{2,  32'h7FFF_FFFF, 32'h8000_0000, 160};
      spans[4] = '{8,  32'h0001_2345, 32'h0001_2345, 120};
      spans[5] = '{4,  32'h0000_0000, 32'h0000_0001, 160};
      spans[6] = '{int'($urandom_range(0, 20)), $urandom(), $urandom(), 200};
      spans[7] = '{1, 32'd0 - $urandom_range(1, 32'h8_0000), $urandom_range(1, 32'h8_0000), 160};
      spans[8] = '{10, 32'hFFFD_0000, 32'h0001_0000, 200};

      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[r]) begin
         if (directed_plan[r].kind == ROW_CSR) begin
            settle();
            write_reg(directed_plan[r].sel, directed_plan[r].data);
         end else begin
            offer_item(directed_plan[r].sel, directed_plan[r].idx, directed_plan[r].data);
            if (directed_plan[r].sel != OP_LOAD) begin
               if (directed_plan[r].typed) begin
                  want.result = directed_plan[r].want;
                  want.error  = directed_plan[r].want_err;
               end else begin
                  want = clenshaw_predict(directed_plan[r].sel, directed_plan[r].data);
               end
               series_q.push_back(want);
            end
         end
      end

      for (int s = 0; s < SPAN_COUNT; s++) begin
         settle();
         write_reg(CSR_DEGREE, ($urandom() & 32'hFFFF_FFC0) | 32'(spans[s].deg));
         write_reg(CSR_START, spans[s].lo);
         write_reg(CSR_END, spans[s].hi);
         for (int k = 0; k < spans[s].items; k++) begin
            case ((k * 4) / spans[s].items)
               0: begin
                  sender_idle = 0;
                  stall_pct   = 0;
               end
               1: begin
                  sender_idle = 58;
                  stall_pct   = 0;
               end
               2: begin
                  sender_idle = 0;
                  stall_pct   = 58;
               end
               default: begin
                  sender_idle = 17;
                  stall_pct   = 17;
               end
            endcase
            if (s == 0 && k == 20) long_hold_go = 1'b1;

            pick = $urandom_range(0, 99);
            op   = (pick < 35) ? OP_LOAD : OP_W'($urandom_range(1, 3));
            if ($urandom_range(0, 1) == 1)
               idx = IDX_W'($urandom_range(0, degree_shadow));
            else
               idx = IDX_W'($urandom());
            // load any coefficient still missing up to the degree first
            if (op != OP_LOAD) begin
               gap = -1;
               for (int j = int'(degree_shadow); j >= 0; j--)
                  if (!coeff_loaded[j]) gap = j;
               if (gap >= 0) begin
                  op  = OP_LOAD;
                  idx = IDX_W'(gap);
               end
            end

            pick = $urandom_range(0, 99);
            den  = longint'(span_hi) - longint'(span_lo);
            if (op == OP_LOAD)
               val = (pick < 60) ? ($urandom_range(0, 32'h8_0000) - 32'h4_0000) : $urandom();
            else if (pick < 4)
               val = 32'h7FFF_FFFF;
            else if (pick < 8)
               val = 32'h8000_0000;
            else if (pick < 75 && den != 0)
               val = VAL_W'(longint'(span_lo) + den * longint'($urandom_range(0, 1024)) / 1024);
            else
               val = $urandom();

            offer_item(op, idx, val);
            if (op != OP_LOAD) series_q.push_back(clenshaw_predict(op, val));
         end
      end

      settle();
      if (fail_count == 0 && series_q.size() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
